// ----- hdl/gmcd_pkg.sv -----
`default_nettype none
package gmcd_pkg;
  localparam int MAX_WIDTH   = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int AW          = $clog2(MAX_WIDTH);
  localparam int WCFG        = 11;
  localparam int HCFG        = 16;
  localparam int MAG_BITS    = 17;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;
  localparam int SUM_BITS    = SQ_BITS + 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_SQ} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_RUN, B_OUT} back_state_t;

  typedef struct packed {
    logic [SQ_BITS-1:0] sq_x;
    logic [SQ_BITS-1:0] sq_y;
    logic               frame_end;
  } job_t;

  typedef struct packed {
    logic [AW:0]      width;
    logic [HCFG-1:0]  height;
  } cfg_t;

  function automatic logic [SAMPLE_BITS-1:0] abs_diff(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b);
    logic [SAMPLE_BITS:0] d;
    logic [SAMPLE_BITS:0] m;
    d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    m = d[SAMPLE_BITS] ? (~d + (SAMPLE_BITS+1)'(1)) : d;
    return m[SAMPLE_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

// ----- hdl/gmcd_in_if.sv -----
`default_nettype none
interface gmcd_in_if;
  logic                                      valid;
  logic                                      ready;
  logic                                      action;
  logic signed [gmcd_pkg::SAMPLE_BITS-1:0]   sample;
  modport source(output valid, action, sample, input ready);
  modport sink(input valid, action, sample, output ready);
endinterface
`default_nettype wire

// ----- hdl/gmcd_out_if.sv -----
`default_nettype none
interface gmcd_out_if;
  logic                            valid;
  logic                            ready;
  logic [gmcd_pkg::MAG_BITS-1:0]   magnitude;
  logic                            frame_end;
  modport source(output valid, magnitude, frame_end, input ready);
  modport sink(input valid, magnitude, frame_end, output ready);
endinterface
`default_nettype wire

// ----- hdl/gradient_magnitude_central_diff.sv -----
`default_nettype none
// Gradient magnitude over a raster stream of signed height samples, with an
// APB register port for width (0x0) and height (0x4). The front end reads
// the line store and forms the differences for each beat, then squares them
// when the beat yields a result (not for an ignored beat or a first-row
// sample). The bit-serial square root holds each result until out_ready is
// high before it loads the next job; it sets the sustained rate, and a
// 4-entry queue lets the front end run ahead. After the last row, send one
// drain beat per column; frame_end marks the final result.
module gradient_magnitude_central_diff (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gmcd_in_if.sink          in_ch,
  gmcd_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int AW = gmcd_pkg::AW;

  logic [gmcd_pkg::WCFG-1:0] width_r;
  logic [gmcd_pkg::HCFG-1:0] height_r;
  gmcd_pkg::cfg_t            cfg;
  gmcd_pkg::job_t            job_in, job_out;
  logic                      push, pop, full, empty, wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gmcd_pkg::WCFG'(1024);
      height_r <= gmcd_pkg::HCFG'(1024);
    end else if (wr) begin
      unique case (paddr[2])
        gmcd_pkg::REG_WIDTH:  width_r  <= pwdata[gmcd_pkg::WCFG-1:0];
        gmcd_pkg::REG_HEIGHT: height_r <= pwdata[gmcd_pkg::HCFG-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gmcd_pkg::REG_WIDTH:  prdata = 32'(width_r);
      gmcd_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:              prdata = '0;
    endcase
    priority if (width_r == '0) cfg.width = (AW+1)'(1);
    else if (width_r > gmcd_pkg::WCFG'(gmcd_pkg::MAX_WIDTH))
      cfg.width = (AW+1)'(gmcd_pkg::MAX_WIDTH);
    else cfg.width = (AW+1)'(width_r);
    cfg.height = (height_r == '0) ? gmcd_pkg::HCFG'(1) : height_r;
  end

  gmcd_front u_front (
    .clk, .rst_n, .in_ch, .cfg, .fifo_full(full), .job(job_in), .push
  );

  gmcd_fifo u_fifo (
    .clk, .rst_n, .push, .wdata(job_in), .pop, .rdata(job_out), .full, .empty
  );

  gmcd_sqrt u_sqrt (
    .clk, .rst_n, .job(job_out), .empty, .pop, .out_ch
  );
endmodule
`default_nettype wire

// ----- hdl/gmcd_front.sv -----
`default_nettype none
module gmcd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  gmcd_in_if.sink             in_ch,
  input  wire gmcd_pkg::cfg_t cfg,
  input  wire logic           fifo_full,
  output gmcd_pkg::job_t      job,
  output logic                push
);
  localparam int SB = gmcd_pkg::SAMPLE_BITS;
  localparam int AW = gmcd_pkg::AW;

  gmcd_pkg::front_state_t state_r, state_nxt;

  logic signed [SB-1:0] prev_mem [gmcd_pkg::MAX_WIDTH];
  logic signed [SB-1:0] old_mem  [gmcd_pkg::MAX_WIDTH];

  logic [AW-1:0]               col_r, drain_r, x_r, x_cur, x_cur1;
  logic [gmcd_pkg::HCFG-1:0]   row_r;
  logic                        act_r, emit_r, fe_r;
  logic signed [SB-1:0]        smp_r, pa_r, pb_r, oa_r, left_r;
  logic [SB-1:0]               adx_r, ady_r, adx, ady;
  logic                        accept, full, x_last, valid_s, valid_d, emit, fe;

  assign accept = in_ch.valid && in_ch.ready;
  assign x_cur  = (in_ch.action == gmcd_pkg::ACT_DRAIN) ? drain_r : col_r;
  assign x_cur1 = x_cur + AW'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      pa_r  <= prev_mem[x_cur];
      pb_r  <= prev_mem[x_cur1];
      oa_r  <= old_mem[x_cur];
      act_r <= in_ch.action;
      smp_r <= in_ch.sample;
      x_r   <= x_cur;
    end
  end

  assign full    = row_r >= cfg.height;
  assign x_last  = ({1'b0, x_r} + (AW+1)'(1)) >= cfg.width;
  assign valid_s = (act_r == gmcd_pkg::ACT_SAMPLE) && !full;
  assign valid_d = (act_r == gmcd_pkg::ACT_DRAIN) && full;
  assign emit    = (valid_s && (row_r != '0)) || valid_d;
  assign fe      = valid_d && x_last;

  always_comb begin
    priority if (cfg.width == (AW+1)'(1)) adx = '0;
    else if (x_r == '0)                    adx = gmcd_pkg::abs_diff(pb_r, pa_r);
    else if (x_last)                       adx = gmcd_pkg::abs_diff(pa_r, left_r);
    else                                   adx = gmcd_pkg::abs_diff(pb_r, left_r);
    if (act_r == gmcd_pkg::ACT_DRAIN) begin
      ady = (row_r >= gmcd_pkg::HCFG'(2)) ? gmcd_pkg::abs_diff(pa_r, oa_r) : '0;
    end else begin
      ady = (row_r == gmcd_pkg::HCFG'(1)) ? gmcd_pkg::abs_diff(smp_r, pa_r)
                                          : gmcd_pkg::abs_diff(smp_r, oa_r);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gmcd_pkg::F_CALC && valid_s) begin
      old_mem[x_r]  <= pa_r;
      prev_mem[x_r] <= smp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gmcd_pkg::F_CALC) begin
      adx_r  <= adx;
      ady_r  <= ady;
      emit_r <= emit;
      fe_r   <= fe;
      if (valid_s || valid_d) left_r <= pa_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gmcd_pkg::F_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gmcd_pkg::F_CALC) begin
        if (valid_s) begin
          if (x_last) begin
            col_r <= '0;
            row_r <= row_r + gmcd_pkg::HCFG'(1);
          end else begin
            col_r <= x_r + AW'(1);
          end
        end else if (valid_d) begin
          if (x_last) begin
            col_r   <= '0;
            row_r   <= '0;
            drain_r <= '0;
          end else begin
            drain_r <= x_r + AW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gmcd_pkg::F_IDLE: if (accept) state_nxt = gmcd_pkg::F_CALC;
      gmcd_pkg::F_CALC: state_nxt = emit ? gmcd_pkg::F_SQ : gmcd_pkg::F_IDLE;
      gmcd_pkg::F_SQ:   state_nxt = gmcd_pkg::F_IDLE;
      default:          state_nxt = gmcd_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = (state_r == gmcd_pkg::F_IDLE) && !fifo_full;
    push          = (state_r == gmcd_pkg::F_SQ) && emit_r;
    job.sq_x      = gmcd_pkg::SQ_BITS'(adx_r) * gmcd_pkg::SQ_BITS'(adx_r);
    job.sq_y      = gmcd_pkg::SQ_BITS'(ady_r) * gmcd_pkg::SQ_BITS'(ady_r);
    job.frame_end = fe_r;
  end

  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == gmcd_pkg::F_CALC)
    else $error("accepted beat not processed");
endmodule
`default_nettype wire

// ----- hdl/gmcd_fifo.sv -----
`default_nettype none
module gmcd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire gmcd_pkg::job_t wdata,
  input  wire logic           pop,
  output gmcd_pkg::job_t      rdata,
  output logic                full,
  output logic                empty
);
  localparam int FA = gmcd_pkg::FIFO_AW;

  gmcd_pkg::job_t  store_r [gmcd_pkg::FIFO_DEPTH];
  logic [FA-1:0]   wp_r, rp_r;
  logic [FA:0]     cnt_r;

  assign full  = cnt_r == (FA+1)'(gmcd_pkg::FIFO_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = store_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) store_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FA'(1);
      if (pop)  rp_r <= rp_r + FA'(1);
      cnt_r <= cnt_r + (FA+1)'(push) - (FA+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue underflow");
endmodule
`default_nettype wire

// ----- hdl/gmcd_sqrt.sv -----
`default_nettype none
module gmcd_sqrt (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gmcd_pkg::job_t job,
  input  wire logic           empty,
  output logic                pop,
  gmcd_out_if.source          out_ch
);
  localparam int MB  = gmcd_pkg::MAG_BITS;
  localparam int RB  = MB + 4;
  localparam int CB  = $clog2(MB);

  gmcd_pkg::back_state_t state_r, state_nxt;

  logic [2*MB-1:0] n_r;
  logic [RB-1:0]   rem_r, rem_s, trial;
  logic [MB-1:0]   root_r;
  logic [CB-1:0]   cnt_r;
  logic            fe_r, done;
  logic [gmcd_pkg::SUM_BITS-1:0] sum;

  assign sum   = gmcd_pkg::SUM_BITS'(job.sq_x) + gmcd_pkg::SUM_BITS'(job.sq_y);
  assign rem_s = {rem_r[RB-3:0], n_r[2*MB-1 -: 2]};
  assign trial = RB'({root_r, 2'b01});
  assign done  = cnt_r == CB'(MB - 1);

  always_ff @(posedge clk) begin
    if (pop) begin
      n_r    <= (2*MB)'(sum);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
      fe_r   <= job.frame_end;
    end else if (state_r == gmcd_pkg::B_RUN) begin
      n_r   <= {n_r[2*MB-3:0], 2'b00};
      cnt_r <= cnt_r + CB'(1);
      if (rem_s >= trial) begin
        rem_r  <= rem_s - trial;
        root_r <= {root_r[MB-2:0], 1'b1};
      end else begin
        rem_r  <= rem_s;
        root_r <= {root_r[MB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gmcd_pkg::B_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gmcd_pkg::B_IDLE: if (!empty) state_nxt = gmcd_pkg::B_RUN;
      gmcd_pkg::B_RUN:  if (done) state_nxt = gmcd_pkg::B_OUT;
      gmcd_pkg::B_OUT:  if (out_ch.ready) state_nxt = gmcd_pkg::B_IDLE;
      default:          state_nxt = gmcd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop              = (state_r == gmcd_pkg::B_IDLE) && !empty;
    out_ch.valid     = state_r == gmcd_pkg::B_OUT;
    out_ch.magnitude = root_r;
    out_ch.frame_end = fe_r;
  end
endmodule
`default_nettype wire
